// File: rtl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the tone and PCM mixer
// Command codes, register indexes, gain ramp coefficients, fixed-point
// constants of the sine table, and small arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpm_pkg;

	// Command codes carried in tuser.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_VOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PCM_VOL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO   = 2'd2;

	localparam int TGT_W  = 16;
	localparam int GAIN_W = 32;
	localparam int SMP_W  = 16;
	localparam int STEP_W = 23;
	localparam int CNT_SMP_W = 24;

	localparam logic [TGT_W-1:0] TONE_TGT_RST = 16'd1638;
	localparam logic [TGT_W-1:0] PCM_TGT_RST  = 16'd6554;

	// Ramp coefficients, Q0.24: about 0.005 and 0.0001.
	localparam int COEF_W = 17;
	localparam logic [COEF_W-1:0] TONE_COEF = 17'd83886;
	localparam logic [COEF_W-1:0] PCM_COEF  = 17'd1678;

	// Shift-add multiplier lanes: one multiplier bit per cycle.
	localparam int MUL_STEPS = COEF_W;
	localparam int CNT_W     = $clog2(MUL_STEPS);
	localparam int ACC_W     = GAIN_W + COEF_W;
	localparam int NUM_LANES = 3;

	// Angle constants of the sine table, Q2.30.
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int SUM_OUT_W = 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAMP,
		ST_GAIN,
		ST_SCALE,
		ST_FINISH
	} state_t;

	function automatic logic [SMP_W-1:0] mag16(input logic signed [SMP_W-1:0] v);
		return v[SMP_W-1] ? SMP_W'(-v) : SMP_W'(v);
	endfunction

	// Applies the sign to an 18-bit magnitude, giving a 20-bit signed term.
	function automatic logic signed [SUM_OUT_W-1:0] signed_term(input logic neg,
			input logic [17:0] m);
		logic signed [SUM_OUT_W-1:0] t;
		t = $signed({2'b00, m});
		return neg ? -t : t;
	endfunction

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SUM_OUT_W-1:0] v);
		if (v > SUM_OUT_W'(32767)) begin
			return 16'sh7FFF;
		end else if (v < -SUM_OUT_W'(32768)) begin
			return 16'sh8000;
		end
		return SMP_W'(v);
	endfunction

endpackage

// File: rtl/tone_and_pcm_mixer.sv
// ----------------------------------------------------------------------------
// tone_and_pcm_mixer: table-sine tone generator with smoothed gains and PCM mix
// A tick runs two passes of the bit-serial multiplier lanes, a gain update
// between them and a finish step; the input reopens only once the finish step
// is done, so a tick is not taken while another is in progress, and a held
// result stalls the finish step. Start, stop and unused commands leave the block idle.
// Reset clears tone state and sets the gains to the target reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_and_pcm_mixer #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpm_pkg::TGT_W-1:0]      cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tone_step [22:0], tone_samples [46:23], pcm_left [62:47],
	// pcm_right [78:63], zero [79]
	input  logic [79:0]                    s_tdata,
	// command [1:0], pcm_valid [2]
	input  logic [2:0]                     s_tuser,
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// left_out [15:0], right_out [31:16], tone_busy [32], zero [39:33]
	output logic [39:0]                    m_tdata
);
	import tpm_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int PH_W   = IDX_W + 16;
	localparam int SUM_W  = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
	localparam int RC_W   = $clog2(SUM_W + 1);
	localparam int SPAN_I = TABLE_ENTRIES * 65536;
	localparam logic [PH_W:0] SPAN = (PH_W+1)'(SPAN_I);

	// Sine table, worked out at elaboration with a Taylor series on the
	// angle folded into the first quadrant.
	logic signed [SMP_W-1:0] sine_tab [TABLE_ENTRIES];

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_sine
		localparam longint unsigned XA =
			(64'd2 * PI_Q30 * 64'(g)) / 64'(TABLE_ENTRIES);
		localparam bit NEG = (XA >= PI_Q30);
		localparam longint unsigned XB = NEG ? (XA - PI_Q30) : XA;
		localparam longint unsigned X  = (XB > HALF_PI_Q30) ? (PI_Q30 - XB) : XB;
		localparam longint unsigned X2 = (X * X) >> 30;
		localparam longint unsigned T1 = ((X * X2) >> 30) / 64'd6;
		localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
		localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
		localparam longint SUM = $signed(X) - $signed(T1) + $signed(T2) - $signed(T3)
			+ $signed(T4) - $signed(T5) + $signed(T6) - $signed(T7);
		localparam longint unsigned POS = (SUM < 0) ? 64'd0 : $unsigned(SUM);
		localparam longint unsigned V0 = (POS * 64'd32767) >> 30;
		localparam longint unsigned V  = (V0 > 64'd32767) ? 64'd32767 : V0;
		assign sine_tab[g] = NEG ? -$signed(SMP_W'(V)) : $signed(SMP_W'(V));
	end

	// Control state.
	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [RC_W-1:0]        red_cnt_q;
	logic                   tone_on_q;
	logic [PH_W-1:0]        phase_acc_q;
	logic [STEP_W-1:0]      phase_inc_q;
	logic [CNT_SMP_W-1:0]   samples_q;
	logic [GAIN_W-1:0]      tone_gain_q, pcm_gain_q;
	logic [TGT_W-1:0]       tone_tgt_q, pcm_tgt_q;
	logic                   stereo_q;
	logic                   m_tvalid_q;

	// Payload registers.
	logic [ACC_W-1:0]       acc_q    [NUM_LANES];
	logic [GAIN_W-1:0]      mcand_q  [NUM_LANES];
	logic [COEF_W-1:0]      mplier_q [NUM_LANES];
	logic                   neg_q    [NUM_LANES];
	logic                   tone_up_q, pcm_up_q;
	logic signed [SMP_W-1:0] sine_q, pcm_left_q, pcm_right_q;
	logic                   pcm_valid_q;
	logic [SUM_W-1:0]       red_sum_q;
	logic [PH_W-1:0]        rem_q;
	logic [39:0]            m_tdata_q;

	// Handshake and sequencing controls.
	logic in_acc, slot_free, red_done, lanes_run, gain_upd, finish;
	logic [1:0] cmd;

	assign in_acc    = s_tvalid && s_tready;
	assign cmd       = s_tuser[1:0];
	assign slot_free = !m_tvalid_q || m_tready;
	assign red_done  = (red_cnt_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_TICK) begin
					state_d = ST_RAMP;
				end
			end
			ST_RAMP: begin
				if (cnt_q == '0) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free && red_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		lanes_run = 1'b0;
		gain_upd  = 1'b0;
		finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_RAMP, ST_SCALE: begin
				lanes_run = 1'b1;
			end
			ST_GAIN: begin
				gain_upd = 1'b1;
			end
			ST_FINISH: begin
				finish = slot_free && red_done;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Request fields.
	logic [STEP_W-1:0]       in_step;
	logic [CNT_SMP_W-1:0]    in_samples;
	logic signed [SMP_W-1:0] in_left, in_right;

	assign in_step    = s_tdata[22:0];
	assign in_samples = s_tdata[46:23];
	assign in_left    = $signed(s_tdata[62:47]);
	assign in_right   = $signed(s_tdata[78:63]);

	// Distance of each gain from its target.
	logic [GAIN_W-1:0] tone_target, pcm_target;
	logic              tone_up, pcm_up;
	logic [GAIN_W-1:0] tone_diff, pcm_diff;

	assign tone_target = {1'b0, tone_tgt_q, 15'b0};
	assign pcm_target  = {1'b0, pcm_tgt_q, 15'b0};
	assign tone_up     = (tone_target >= tone_gain_q);
	assign pcm_up      = (pcm_target >= pcm_gain_q);
	assign tone_diff   = tone_up ? (tone_target - tone_gain_q) : (tone_gain_q - tone_target);
	assign pcm_diff    = pcm_up ? (pcm_target - pcm_gain_q) : (pcm_gain_q - pcm_target);

	// Gains after the ramp step; lane 0 holds the tone product, lane 1 the PCM one.
	logic [GAIN_W-1:0] tone_delta, pcm_delta, tone_gain_new, pcm_gain_new;

	assign tone_delta    = GAIN_W'(acc_q[0][ACC_W-1:24]);
	assign pcm_delta     = GAIN_W'(acc_q[1][ACC_W-1:24]);
	assign tone_gain_new = tone_up_q ? (tone_gain_q + tone_delta) : (tone_gain_q - tone_delta);
	assign pcm_gain_new  = pcm_up_q ? (pcm_gain_q + pcm_delta) : (pcm_gain_q - pcm_delta);

	logic signed [SMP_W-1:0] right_src;
	assign right_src = stereo_q ? pcm_right_q : pcm_left_q;

	// Mix and saturate.
	logic signed [SUM_OUT_W-1:0] tone_term, left_term, right_term, left_sum, right_sum;
	logic [CNT_SMP_W-1:0]        samples_next;
	logic                        tone_on_next;

	assign tone_term  = tone_on_q ? signed_term(neg_q[0], acc_q[0][47:30]) : '0;
	assign left_term  = pcm_valid_q ? signed_term(neg_q[1], acc_q[1][47:30]) : '0;
	assign right_term = pcm_valid_q ? signed_term(neg_q[2], acc_q[2][47:30]) : '0;
	assign left_sum   = tone_term + left_term;
	assign right_sum  = tone_term + right_term;

	assign samples_next = (samples_q != '0) ? (samples_q - 1'b1) : samples_q;
	assign tone_on_next = tone_on_q && (samples_next != '0);

	// Phase reduction step: long-division remainder, one sum bit per cycle.
	logic [PH_W:0] red_trial;
	assign red_trial = {rem_q, red_sum_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			red_cnt_q   <= '0;
			tone_on_q   <= 1'b0;
			phase_acc_q <= '0;
			phase_inc_q <= '0;
			samples_q   <= '0;
			tone_tgt_q  <= TONE_TGT_RST;
			pcm_tgt_q   <= PCM_TGT_RST;
			stereo_q    <= 1'b0;
			tone_gain_q <= {1'b0, TONE_TGT_RST, 15'b0};
			pcm_gain_q  <= {1'b0, PCM_TGT_RST, 15'b0};
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TONE_VOL: tone_tgt_q <= cfg_data;
					REG_PCM_VOL:  pcm_tgt_q  <= cfg_data;
					REG_STEREO:   stereo_q   <= cfg_data[0];
					default:      ;
				endcase
			end

			if (in_acc) begin
				case (cmd)
					CMD_START: begin
						if (in_samples != '0) begin
							phase_inc_q <= in_step;
							samples_q   <= in_samples;
							tone_on_q   <= 1'b1;
						end
					end
					CMD_STOP: begin
						tone_on_q <= 1'b0;
					end
					CMD_TICK: begin
						cnt_q     <= CNT_W'(MUL_STEPS - 1);
						red_cnt_q <= RC_W'(SUM_W);
					end
					default: ;
				endcase
			end else begin
				if (lanes_run) begin
					cnt_q <= cnt_q - 1'b1;
				end
				if (gain_upd) begin
					cnt_q       <= CNT_W'(MUL_STEPS - 1);
					tone_gain_q <= tone_gain_new;
					pcm_gain_q  <= pcm_gain_new;
				end
				if (!red_done) begin
					red_cnt_q <= red_cnt_q - 1'b1;
				end
			end

			if (finish) begin
				if (tone_on_q) begin
					phase_acc_q <= rem_q;
					samples_q   <= samples_next;
					tone_on_q   <= tone_on_next;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_TICK) begin
			pcm_valid_q <= s_tuser[2];
			pcm_left_q  <= in_left;
			pcm_right_q <= in_right;
			sine_q      <= sine_tab[phase_acc_q[PH_W-1:16]];
			tone_up_q   <= tone_up;
			pcm_up_q    <= pcm_up;
			red_sum_q   <= SUM_W'(phase_acc_q) + SUM_W'(phase_inc_q);
			rem_q       <= '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				acc_q[i] <= '0;
				neg_q[i] <= 1'b0;
			end
			mcand_q[0]  <= tone_diff;
			mplier_q[0] <= TONE_COEF;
			mcand_q[1]  <= pcm_diff;
			mplier_q[1] <= PCM_COEF;
			mcand_q[2]  <= '0;
			mplier_q[2] <= '0;
		end else begin
			if (!red_done) begin
				rem_q     <= (red_trial >= SPAN) ? PH_W'(red_trial - SPAN) : PH_W'(red_trial);
				red_sum_q <= {red_sum_q[SUM_W-2:0], 1'b0};
			end
			if (gain_upd) begin
				for (int i = 0; i < NUM_LANES; i++) begin
					acc_q[i] <= '0;
				end
				mcand_q[0]  <= tone_gain_new;
				mplier_q[0] <= COEF_W'(mag16(sine_q));
				neg_q[0]    <= sine_q[SMP_W-1];
				mcand_q[1]  <= pcm_gain_new;
				mplier_q[1] <= COEF_W'(mag16(pcm_left_q));
				neg_q[1]    <= pcm_left_q[SMP_W-1];
				mcand_q[2]  <= pcm_gain_new;
				mplier_q[2] <= COEF_W'(mag16(right_src));
				neg_q[2]    <= right_src[SMP_W-1];
			end else if (lanes_run) begin
				// Shift-add, multiplier bits taken from the top down.
				for (int i = 0; i < NUM_LANES; i++) begin
					acc_q[i]    <= {acc_q[i][ACC_W-2:0], 1'b0}
						+ (mplier_q[i][COEF_W-1] ? ACC_W'(mcand_q[i]) : '0);
					mplier_q[i] <= {mplier_q[i][COEF_W-2:0], 1'b0};
				end
			end
		end

		if (finish) begin
			m_tdata_q <= {7'b0, tone_on_next, sat16(right_sum), sat16(left_sum)};
		end
	end

endmodule

// File: dv/tone_and_pcm_mixer_tb.sv
// ----------------------------------------------------------------------------
// tone_and_pcm_mixer_tb: self-checking testbench of the tone and PCM mixer
// Drives start, stop, tick and unused commands on the input stream and
// reprograms the gain targets and the stereo mode between phases. A local
// model of the sine table, the gain glides and the mix predicts every tick.
// Each output request is checked field by field against the oldest
// prediction. Both stream sides idle in random bursts, and one long output
// hold fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_and_pcm_mixer_tb;
	import tpm_pkg::*;

	localparam int TABLE_N = 256;
	localparam longint unsigned ANGLE_PI   = 64'd3373259426;
	localparam longint unsigned ANGLE_HALF = 64'd1686629713;
	localparam longint unsigned GLIDE_TONE = 64'd83886;
	localparam longint unsigned GLIDE_PCM  = 64'd1678;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct {
		logic [1:0]         cmd;
		logic [22:0]        step;
		logic [23:0]        count;
		logic               pcm_on;
		logic signed [15:0] pl;
		logic signed [15:0] pr;
	} mixer_req_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               busy;
	} mix_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TGT_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [79:0]          s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;

	tone_and_pcm_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Mixer model state.
	logic signed [15:0] sine_tab [0:TABLE_N-1];
	logic [23:0] tone_phase;
	logic [23:0] tone_incr;
	logic [23:0] tone_left;
	logic        tone_active;
	logic [31:0] tone_gain;
	logic [31:0] pcm_gain;
	logic [15:0] tone_tgt;
	logic [15:0] pcm_tgt;
	logic        stereo_mode;

	mix_result_t mix_expected [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          src_idle_on = 1'b0;
	bit          sink_idle_on = 1'b0;
	int          sink_hold_req = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Integer Taylor series of sin on an angle folded into the first quadrant.
	function automatic logic signed [15:0] sine_value(input int i);
		longint unsigned x, x2, term, v;
		longint acc;
		bit neg;
		int r;
		x = (64'd2 * ANGLE_PI * i) / TABLE_N;
		neg = 1'b0;
		if (x >= ANGLE_PI) begin
			x = x - ANGLE_PI;
			neg = 1'b1;
		end
		if (x > ANGLE_HALF) begin
			x = ANGLE_PI - x;
		end
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x2) >> 30;
			term = term / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = ($unsigned(acc) * 64'd32767) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		r = int'(v);
		return 16'(neg ? -r : r);
	endfunction

	// Moves a Q2.30 gain a fixed fraction toward a Q1.15 target.
	function automatic logic [31:0] glide(input logic [31:0] gain, input logic [15:0] tgt,
			input longint unsigned k);
		logic [31:0] aim;
		longint unsigned diff, d;
		aim = {1'b0, tgt, 15'd0};
		if (aim >= gain) begin
			diff = aim - gain;
			d = (diff * k) >> 24;
			return gain + d[31:0];
		end
		diff = gain - aim;
		d = (diff * k) >> 24;
		return gain - d[31:0];
	endfunction

	function automatic int apply_gain(input int s, input logic [31:0] g);
		longint unsigned m;
		int r;
		m = (s < 0) ? -s : s;
		r = int'((m * g) >> 30);
		return (s < 0) ? -r : r;
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	function automatic mixer_req_t make_req(input logic [1:0] cmd, input logic [22:0] step,
			input logic [23:0] count, input logic pcm_on, input logic signed [15:0] pl,
			input logic signed [15:0] pr);
		mixer_req_t r;
		r.cmd = cmd;
		r.step = step;
		r.count = count;
		r.pcm_on = pcm_on;
		r.pl = pl;
		r.pr = pr;
		return r;
	endfunction

	function automatic mixer_req_t rand_req();
		int sel;
		logic [23:0] n;
		logic [1:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 78) begin
			c = CMD_TICK;
		end else if (sel < 90) begin
			c = CMD_START;
		end else if (sel < 97) begin
			c = CMD_STOP;
		end else begin
			c = CMD_UNUSED;
		end
		sel = $urandom_range(0, 19);
		if (sel < 14) begin
			n = 24'($urandom_range(1, 60));
		end else if (sel < 19) begin
			n = 24'($urandom_range(1, 24'hFFFFFF));
		end else begin
			n = 24'd0;
		end
		return make_req(c, 23'($urandom), n, $urandom_range(0, 3) != 0,
			16'($urandom), 16'($urandom));
	endfunction

	task automatic model_reset();
		for (int i = 0; i < TABLE_N; i++) begin
			sine_tab[i] = sine_value(i);
		end
		tone_phase = '0;
		tone_incr = '0;
		tone_left = '0;
		tone_active = 1'b0;
		tone_tgt = 16'd1638;
		pcm_tgt = 16'd6554;
		stereo_mode = 1'b0;
		tone_gain = {1'b0, tone_tgt, 15'd0};
		pcm_gain = {1'b0, pcm_tgt, 15'd0};
	endtask

	task automatic predict_mix(input mixer_req_t r);
		int lsum, rsum, t, l;
		mix_result_t res;
		case (r.cmd)
			CMD_START: begin
				if (r.count != 24'd0) begin
					tone_incr = {1'b0, r.step};
					tone_left = r.count;
					tone_active = 1'b1;
				end
			end
			CMD_STOP: begin
				tone_active = 1'b0;
			end
			CMD_TICK: begin
				tone_gain = glide(tone_gain, tone_tgt, GLIDE_TONE);
				pcm_gain = glide(pcm_gain, pcm_tgt, GLIDE_PCM);
				lsum = 0;
				rsum = 0;
				if (tone_active) begin
					t = apply_gain(sine_tab[tone_phase[23:16]], tone_gain);
					lsum += t;
					rsum += t;
					tone_phase = tone_phase + tone_incr;
					if (tone_left != 24'd0) begin
						tone_left = tone_left - 24'd1;
					end
					if (tone_left == 24'd0) begin
						tone_active = 1'b0;
					end
				end
				if (r.pcm_on) begin
					l = apply_gain(r.pl, pcm_gain);
					lsum += l;
					rsum += stereo_mode ? apply_gain(r.pr, pcm_gain) : l;
				end
				res.left = clamp16(lsum);
				res.right = clamp16(rsum);
				res.busy = tone_active;
				mix_expected.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	// Sends one request; the valid stays high afterward unless a gap follows.
	task automatic send_req(input mixer_req_t r);
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, r.pr, r.pl, r.count, r.step};
		s_tuser <= {r.pcm_on, r.cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_mix(r);
	endtask

	// Lowers the input and waits until every predicted result has come out.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mix_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TONE_VOL: tone_tgt = value;
			REG_PCM_VOL:  pcm_tgt = value;
			REG_STEREO:   stereo_mode = value[0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh7FFF, 16'sh8000));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh8000, 16'sh7FFF));
		// A start with zero length must leave the tone off.
		send_req(make_req(CMD_START, 23'h7FFFFF, 24'd0, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_UNUSED, 23'h7FFFFF, 24'hFFFFFF, 1'b1, 16'sh7FFF, 16'sh7FFF));
		send_req(make_req(CMD_START, 23'h7FFFFF, 24'd3, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sd1000, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, -16'sd1, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_START, 23'h010000, 24'hFFFFFF, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sd0, 16'sd0));
		// Restart while the tone plays keeps the phase.
		send_req(make_req(CMD_START, 23'h000001, 24'd2, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh7FFF, 16'sd0));
		send_req(make_req(CMD_STOP, 23'h7FFFFF, 24'hFFFFFF, 1'b1, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sd0, 16'sd0));
		drain_results();
		write_reg(REG_STEREO, 16'hFFFF);
		write_reg(REG_TONE_VOL, 16'hFFFF);
		write_reg(REG_PCM_VOL, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_req(make_req(CMD_START, 23'h400000, 24'd16, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh8000, 16'sh7FFF));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh7FFF, 16'sh8000));
		send_req(make_req(CMD_TICK, '0, '0, 1'b0, 16'sh7FFF, 16'sh7FFF));
		drain_results();
		write_reg(REG_TONE_VOL, 16'd0);
		write_reg(REG_PCM_VOL, 16'd0);
		write_reg(REG_STEREO, 16'd0);
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh7FFF, 16'sh8000));
		send_req(make_req(CMD_STOP, '0, '0, 1'b0, 16'sd0, 16'sd0));
		send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'sh8000, 16'sh8000));
	endtask

	// Random traffic over several gain and stereo settings, extremes included.
	task automatic test_random_phases();
		logic [15:0] tv, pv, sv;
		for (int p = 0; p < 6; p++) begin
			drain_results();
			case (p)
				0: begin tv = 16'd32768; pv = 16'd0;     sv = 16'd0; end
				1: begin tv = 16'd65535; pv = 16'd65535; sv = 16'd1; end
				2: begin tv = 16'd2720;  pv = 16'd8192;  sv = 16'd0; end
				3: begin tv = 16'd0;     pv = 16'd32768; sv = 16'd1; end
				4: begin tv = 16'd10813; pv = 16'd16384; sv = 16'd1; end
				default: begin
					tv = 16'($urandom);
					pv = 16'($urandom);
					sv = 16'($urandom);
				end
			endcase
			write_reg(REG_TONE_VOL, tv);
			write_reg(REG_PCM_VOL, pv);
			write_reg(REG_STEREO, sv);
			// Phase 4 runs without any idling.
			src_idle_on = (p != 4);
			sink_idle_on = (p != 4);
			repeat (120) send_req(rand_req());
		end
	endtask

	// The receiver stalls for a long stretch while ticks keep coming.
	task automatic test_output_hold();
		drain_results();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold_req = 400;
		repeat (20) send_req(make_req(CMD_TICK, '0, '0, 1'b1, 16'($urandom), 16'($urandom)));
	endtask

	task automatic test_tail_stream();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (60) send_req(rand_req());
	endtask

	// Output ready: random stall bursts, or a long hold when one is requested.
	initial begin
		int n;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req > 0) begin
				n = sink_hold_req;
				sink_hold_req = 0;
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		end
	endtask

	always @(posedge clk) begin
		mix_result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.left = m_tdata[15:0];
			got.right = m_tdata[31:16];
			got.busy = m_tdata[32];
			if (mix_expected.size() == 0) begin
				note_mismatch("unexpected result, left_out", 0, got.left);
			end else begin
				want = mix_expected.pop_front();
				if (got.left !== want.left) begin
					note_mismatch("left_out", want.left, got.left);
				end
				if (got.right !== want.right) begin
					note_mismatch("right_out", want.right, got.right);
				end
				if (got.busy !== want.busy) begin
					note_mismatch("tone_busy", want.busy, got.busy);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		model_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phases();
		test_output_hold();
		test_tail_stream();
		drain_results();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
